[rtl/icph_pkg.sv]
// ============================================================================
// icph_pkg: shared types and constants for the checksum block
// Holds the kind codes, register indexes, reset values, the struct types
// passed between modules and the end-around-carry adder function.
// ============================================================================
package icph_pkg;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_UDP   = 2'd1;
    localparam logic [1:0] KIND_TCP   = 2'd2;

    localparam logic REG_UDP_PROTO = 1'b0;
    localparam logic REG_TCP_PROTO = 1'b1;

    localparam logic [7:0]  UDP_PROTO_RESET   = 8'd17;
    localparam logic [7:0]  TCP_PROTO_RESET   = 8'd6;
    localparam logic [15:0] PSEUDO_LEN_OFFSET = 16'd8;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;

    typedef struct packed {
        logic [7:0] udp_proto;
        logic [7:0] tcp_proto;
    } t_cfg;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic        length_error;
    } t_result;

    // Ones'-complement add of two 16-bit words with the carry wrapped around.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'b0, s[16]};
        end
    endfunction

endpackage

[rtl/icph_cfg.sv]
// ============================================================================
// icph_cfg: configuration registers
// APB-style register file holding the UDP and TCP protocol numbers.
// ============================================================================
module icph_cfg
    import icph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    logic reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.udp_proto <= UDP_PROTO_RESET;
            r_cfg.tcp_proto <= TCP_PROTO_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_UDP_PROTO: r_cfg.udp_proto <= pwdata[7:0];
                REG_TCP_PROTO: r_cfg.tcp_proto <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_UDP_PROTO: prdata = {24'b0, r_cfg.udp_proto};
            REG_TCP_PROTO: prdata = {24'b0, r_cfg.tcp_proto};
            default:       prdata = 32'b0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/icph_accum.sv]
// ============================================================================
// icph_accum: input register, running sum and final checksum logic
// Registers each byte, adds completed words into the running sum with an
// end-around carry, and forms the checksum when the last byte arrives.
// ============================================================================
module icph_accum
    import icph_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic [1:0] i_kind,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res
);

    logic        r_in_valid;
    logic [7:0]  r_data;
    logic        r_last;
    logic [1:0]  r_kind;

    logic [15:0] r_sum;
    logic [7:0]  r_held;
    logic        r_odd;
    logic [15:0] r_count;

    logic        adv;
    logic [15:0] n_count;
    logic [15:0] word;
    logic [15:0] n_sum;
    logic        pseudo;
    logic [7:0]  proto;
    logic [15:0] len_term;
    logic [15:0] pseudo_sum;
    logic [15:0] final_sum;

    // The held byte advances when it is an ordinary byte or when the
    // output stage can take the result it produces.
    assign adv         = r_in_valid && (!r_last || i_res_ready);
    assign o_ready     = !r_in_valid || adv;
    assign o_res_valid = r_in_valid && r_last;

    assign n_count = (r_count == COUNT_MAX) ? r_count : r_count + 16'd1;
    // An even position that ends the message is padded with a zero low byte.
    assign word    = r_odd ? {r_held, r_data} : {r_data, 8'h00};
    assign n_sum   = oc_add(r_sum, word);

    assign pseudo     = (r_kind == KIND_UDP) || (r_kind == KIND_TCP);
    assign proto      = (r_kind == KIND_UDP) ? i_cfg.udp_proto : i_cfg.tcp_proto;
    assign len_term   = n_count - PSEUDO_LEN_OFFSET;
    assign pseudo_sum = pseudo ? oc_add({8'b0, proto}, len_term) : 16'b0;
    assign final_sum  = oc_add(n_sum, pseudo_sum);

    assign o_res.checksum_value = ~final_sum;
    assign o_res.length_error   = pseudo && (n_count < PSEUDO_LEN_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
            r_kind <= i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= 16'b0;
            r_held  <= 8'b0;
            r_odd   <= 1'b0;
            r_count <= 16'b0;
        end else if (adv) begin
            if (r_last) begin
                r_sum   <= 16'b0;
                r_held  <= 8'b0;
                r_odd   <= 1'b0;
                r_count <= 16'b0;
            end else begin
                r_count <= n_count;
                if (r_odd) begin
                    r_sum <= n_sum;
                    r_odd <= 1'b0;
                end else begin
                    r_held <= r_data;
                    r_odd  <= 1'b1;
                end
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_last |=> (r_sum == 16'b0) && !r_odd && (r_count == 16'b0))
        else $error("state not cleared after the last byte");

    a_parity_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != COUNT_MAX |-> r_count[0] == r_odd)
        else $error("odd-byte flag disagrees with the byte count");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_data) && $stable(r_last))
        else $error("stalled byte was lost or changed");

endmodule

[rtl/icph_outbuf.sv]
// ============================================================================
// icph_outbuf: result output register
// Holds one finished checksum until the downstream side takes it.
// ============================================================================
module icph_outbuf
    import icph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    output logic        o_res_ready,
    input  t_result     i_res,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_checksum_value,
    output logic        o_length_error
);

    logic    r_out_valid;
    t_result r_out;

    assign o_res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_out_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_out <= i_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_checksum_value = r_out.checksum_value;
    assign o_length_error   = r_out.length_error;

endmodule

[rtl/internet_checksum_pseudo_header.sv]
// ============================================================================
// internet_checksum_pseudo_header: byte-serial Internet checksum
// Path: a last byte sits in the input register; its checksum is formed from it
// combinationally into the output register. Throughput: one byte per cycle,
// but a last byte stalls while the output register is full and not emptied.
// Reset (synchronous, active low) clears the sum, count and both valid stages,
// and loads the protocol numbers with 17 for UDP and 6 for TCP.
// ============================================================================
//
// Bytes arrive one per transfer on the input channel. Each byte is first
// captured in an input register. Pairs of bytes form big-endian 16-bit words
// that are added into a running ones'-complement sum. When the transfer
// carries the last byte, the block pads a lone high byte with a zero low
// byte, adds the pseudo-header protocol number and length term for UDP or
// TCP, complements the total and places it in the output register. The
// running state then returns to zero for the next message.
//
// The output register lets a new byte be taken while a finished checksum
// still waits for its transfer; only a last byte stalls while the output
// register is full and not being emptied.
//
// Registers (APB, byte addresses): 0x0 UDP protocol number, 0x4 TCP
// protocol number, both in the low 8 bits.
module internet_checksum_pseudo_header
    import icph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_kind,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_checksum_value,
    output logic        o_length_error,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    res_ready;

    // Protocol number registers.
    icph_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register, running sum and checksum formation.
    icph_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_kind      (i_kind),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Output register for finished checksums.
    icph_outbuf u_outbuf (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_res_valid      (res_valid),
        .o_res_ready      (res_ready),
        .i_res            (res),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_checksum_value (o_checksum_value),
        .o_length_error   (o_length_error)
    );

endmodule
